### rtl/arn_pkg.sv
// ----------------------------------------------------------------------------
// arn_pkg
// shared constants and sine polynomial steps for the rotate and normalize
// pipeline
// ----------------------------------------------------------------------------
package arn_pkg;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam int SIN_A = 51472;
   localparam int SIN_B = 21024;
   localparam int SIN_C = 2320;

   localparam int OUT_WIDTH = 16;
   localparam int UNIT = 16384;

   // scaled magnitudes stay below 2^31
   localparam int MAG_WIDTH = 31;
   // sum of three squares of 31 bit values
   localparam int SUM_WIDTH = 64;
   localparam int ROOT_WIDTH = 32;
   // mag*16384 + n/2
   localparam int NUM_WIDTH = MAG_WIDTH + 15;
   localparam int QUO_WIDTH = 16;

   // quarter-wave polynomial, q15 result, input q14 fraction of a quadrant
   function automatic logic [15:0] sine_x2(input logic [14:0] u);
      logic [29:0] uu;
      uu = 30'(u) * 30'(u);
      return 16'(uu >> 14);
   endfunction

   function automatic logic [15:0] sine_t(input logic [15:0] x2);
      logic [27:0] cx;
      cx = 28'(SIN_C) * 28'(x2);
      return 16'(SIN_B) - 16'(cx >> 14);
   endfunction

   function automatic logic [16:0] sine_r(input logic [15:0] t, input logic [15:0] x2);
      logic [31:0] tx;
      tx = 32'(t) * 32'(x2);
      return 17'(SIN_A) - 17'(tx >> 14);
   endfunction

   function automatic logic [16:0] sine_p(input logic [16:0] r, input logic [14:0] u);
      logic [31:0] ru;
      logic [17:0] p;
      ru = 32'(r) * 32'(u);
      p = 18'(ru >> 14);
      if (p > 18'd32768) p = 18'd32768;
      return p[16:0];
   endfunction

endpackage

### rtl/arn_rotate.sv
// ----------------------------------------------------------------------------
// arn_rotate
// sine/cosine polynomial and axis rotation, four stages, products in q15 scale
// ----------------------------------------------------------------------------
module arn_rotate #(
   parameter int COMP_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         in_valid,
   input  logic [1:0]                   in_axis,
   input  logic [15:0]                  in_angle,
   input  logic signed [COMP_WIDTH-1:0] in_x,
   input  logic signed [COMP_WIDTH-1:0] in_y,
   input  logic signed [COMP_WIDTH-1:0] in_z,
   output logic                         out_valid,
   output logic signed [COMP_WIDTH+17:0] out_rx,
   output logic signed [COMP_WIDTH+17:0] out_ry,
   output logic signed [COMP_WIDTH+17:0] out_rz
);
   import arn_pkg::*;

   localparam int RW = COMP_WIDTH + 18;

   // squared fractions and first polynomial term
   logic                         v1_ff;
   logic [1:0]                   axis1_ff, quad1_ff;
   logic [14:0]                  us1_ff, uc1_ff;
   logic [15:0]                  x2s1_ff, x2c1_ff, ts1_ff, tc1_ff;
   logic signed [COMP_WIDTH-1:0] px1_ff, py1_ff, pz1_ff;
   logic [14:0]                  us_in, uc_in;
   logic [15:0]                  x2s_in, x2c_in, ts_in, tc_in;

   // second polynomial term
   logic                         v2_ff;
   logic [1:0]                   axis2_ff, quad2_ff;
   logic [14:0]                  us2_ff, uc2_ff;
   logic [16:0]                  rs2_ff, rc2_ff;
   logic signed [COMP_WIDTH-1:0] px2_ff, py2_ff, pz2_ff;
   logic [16:0]                  rs_in, rc_in;

   // sine and cosine over the full turn
   logic                         v3_ff;
   logic [1:0]                   axis3_ff;
   logic signed [17:0]           sn3_ff, cs3_ff;
   logic signed [COMP_WIDTH-1:0] px3_ff, py3_ff, pz3_ff;
   logic signed [17:0]           s0, c0, sn_in, cs_in;

   // rotation
   logic                         v4_ff;
   logic signed [RW-1:0]         rx_ff, ry_ff, rz_ff;
   logic signed [RW-1:0]         rx_in, ry_in, rz_in;
   logic signed [RW-1:0]         cx, cy, cz, sx, sy, sz, ux, uy, uz;

   always_comb begin
      us_in = {1'b0, in_angle[13:0]};
      uc_in = 15'd16384 - us_in;
      x2s_in = sine_x2(us_in);
      x2c_in = sine_x2(uc_in);
      ts_in = sine_t(x2s_in);
      tc_in = sine_t(x2c_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
      end
      if (advance) begin
         axis1_ff <= in_axis;
         quad1_ff <= in_angle[15:14];
         us1_ff <= us_in;
         uc1_ff <= uc_in;
         x2s1_ff <= x2s_in;
         x2c1_ff <= x2c_in;
         ts1_ff <= ts_in;
         tc1_ff <= tc_in;
         px1_ff <= in_x;
         py1_ff <= in_y;
         pz1_ff <= in_z;
      end
   end

   always_comb begin
      rs_in = sine_r(ts1_ff, x2s1_ff);
      rc_in = sine_r(tc1_ff, x2c1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
      if (advance) begin
         axis2_ff <= axis1_ff;
         quad2_ff <= quad1_ff;
         us2_ff <= us1_ff;
         uc2_ff <= uc1_ff;
         rs2_ff <= rs_in;
         rc2_ff <= rc_in;
         px2_ff <= px1_ff;
         py2_ff <= py1_ff;
         pz2_ff <= pz1_ff;
      end
   end

   always_comb begin
      s0 = 18'(sine_p(rs2_ff, us2_ff));
      c0 = 18'(sine_p(rc2_ff, uc2_ff));
      case (quad2_ff)
         2'd0: begin sn_in = s0; cs_in = c0; end
         2'd1: begin sn_in = c0; cs_in = -s0; end
         2'd2: begin sn_in = -s0; cs_in = -c0; end
         default: begin sn_in = -c0; cs_in = s0; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
      end
      if (advance) begin
         axis3_ff <= axis2_ff;
         sn3_ff <= sn_in;
         cs3_ff <= cs_in;
         px3_ff <= px2_ff;
         py3_ff <= py2_ff;
         pz3_ff <= pz2_ff;
      end
   end

   always_comb begin
      cx = RW'(cs3_ff) * RW'(px3_ff);
      cy = RW'(cs3_ff) * RW'(py3_ff);
      cz = RW'(cs3_ff) * RW'(pz3_ff);
      sx = RW'(sn3_ff) * RW'(px3_ff);
      sy = RW'(sn3_ff) * RW'(py3_ff);
      sz = RW'(sn3_ff) * RW'(pz3_ff);
      ux = RW'(px3_ff) <<< 15;
      uy = RW'(py3_ff) <<< 15;
      uz = RW'(pz3_ff) <<< 15;
      rx_in = ux;
      ry_in = uy;
      rz_in = uz;
      case (axis3_ff)
         AXIS_X: begin
            ry_in = cy - sz;
            rz_in = sy + cz;
         end
         AXIS_Y: begin
            rx_in = cx + sz;
            rz_in = cz - sx;
         end
         AXIS_Z: begin
            rx_in = cx - sy;
            ry_in = sx + cy;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (advance) begin
         v4_ff <= v3_ff;
      end
      if (advance) begin
         rx_ff <= rx_in;
         ry_ff <= ry_in;
         rz_ff <= rz_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_rx = rx_ff;
   assign out_ry = ry_ff;
   assign out_rz = rz_ff;

endmodule

### rtl/arn_sqrt.sv
// ----------------------------------------------------------------------------
// arn_sqrt
// pipelined restoring square root, one result bit per stage
// ----------------------------------------------------------------------------
module arn_sqrt #(
   parameter int SW = 64,
   parameter int CW = 120
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [SW-1:0]         in_sum,
   input  logic [CW-1:0]         in_carry,
   output logic                  out_valid,
   output logic [SW/2-1:0]       out_root,
   output logic [CW-1:0]         out_carry
);
   localparam int N = SW / 2;

   logic [N:1]    v_ff;
   logic [SW-1:0] rem_ff [1:N];
   logic [N-1:0]  root_ff [1:N];
   logic [CW-1:0] car_ff [1:N];

   for (genvar k = 0; k < N; k++) begin : g_bit
      localparam int B = N - 1 - k;
      logic          v_q;
      logic [SW-1:0] rem_q;
      logic [N-1:0]  root_q;
      logic [CW-1:0] car_q;
      logic [SW-1:0] trial;
      logic [SW-1:0] rem_in;
      logic [N-1:0]  root_in;
      if (k == 0) begin : g_first
         assign v_q = in_valid;
         assign rem_q = in_sum;
         assign root_q = '0;
         assign car_q = in_carry;
      end else begin : g_next
         assign v_q = v_ff[k];
         assign rem_q = rem_ff[k];
         assign root_q = root_ff[k];
         assign car_q = car_ff[k];
      end
      always_comb begin
         // square increment (2*root + 2^B) << B against remaining
         trial = ((SW'(root_q) << 1) | (SW'(1) << B)) << B;
         if (rem_q >= trial) begin
            rem_in = rem_q - trial;
            root_in = root_q | (N'(1) << B);
         end else begin
            rem_in = rem_q;
            root_in = root_q;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (advance) begin
            v_ff[k+1] <= v_q;
         end
         if (advance) begin
            rem_ff[k+1] <= rem_in;
            root_ff[k+1] <= root_in;
            car_ff[k+1] <= car_q;
         end
      end
   end

   assign out_valid = v_ff[N];
   assign out_root = root_ff[N];
   assign out_carry = car_ff[N];

endmodule

### rtl/arn_divide.sv
// ----------------------------------------------------------------------------
// arn_divide
// three lanes of pipelined restoring division, one quotient bit per stage
// ----------------------------------------------------------------------------
module arn_divide #(
   parameter int NW = 46,
   parameter int DW = 32,
   parameter int QW = 16,
   parameter int CW = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic [NW-1:0]        in_num [3],
   input  logic [DW-1:0]        in_den,
   input  logic [CW-1:0]        in_carry,
   output logic                 out_valid,
   output logic [QW-1:0]        out_quo [3],
   output logic                 out_sat [3],
   output logic [CW-1:0]        out_carry
);
   // remainder is QW+1 bits wider than the divisor; quotient overflow is flagged by hi
   localparam int RW = DW + QW + 1;

   logic [QW:1]   v_ff;
   logic [NW-1:0] num_ff [1:QW][3];
   logic [RW-1:0] rem_ff [1:QW][3];
   logic [QW-1:0] quo_ff [1:QW][3];
   logic [DW-1:0] den_ff [1:QW];
   logic [CW-1:0] car_ff [1:QW];
   logic          hi_ff [1:QW][3];

   for (genvar k = 0; k < QW; k++) begin : g_step
      localparam int B = QW - 1 - k;
      logic          v_q;
      logic [NW-1:0] num_q [3];
      logic [RW-1:0] rem_q [3];
      logic [QW-1:0] quo_q [3];
      logic [DW-1:0] den_q;
      logic [CW-1:0] car_q;
      logic          hi_q [3];
      logic [RW-1:0] rem_in [3];
      logic [QW-1:0] quo_in [3];
      logic [RW-1:0] sh [3];
      if (k == 0) begin : g_first
         always_comb begin
            v_q = in_valid;
            den_q = in_den;
            car_q = in_carry;
            for (int l = 0; l < 3; l++) begin
               num_q[l] = in_num[l];
               // high part: anything at or above 2^QW in quotient is flagged to saturate
               rem_q[l] = RW'(in_num[l] >> QW);
               quo_q[l] = '0;
               hi_q[l] = (RW'(in_num[l] >> QW) >= RW'(in_den));
            end
         end
      end else begin : g_next
         always_comb begin
            v_q = v_ff[k];
            den_q = den_ff[k];
            car_q = car_ff[k];
            for (int l = 0; l < 3; l++) begin
               num_q[l] = num_ff[k][l];
               rem_q[l] = rem_ff[k][l];
               quo_q[l] = quo_ff[k][l];
               hi_q[l] = hi_ff[k][l];
            end
         end
      end
      always_comb begin
         for (int l = 0; l < 3; l++) begin
            sh[l] = {rem_q[l][RW-2:0], num_q[l][B]};
            if (sh[l] >= RW'(den_q)) begin
               rem_in[l] = sh[l] - RW'(den_q);
               quo_in[l] = quo_q[l] | (QW'(1) << B);
            end else begin
               rem_in[l] = sh[l];
               quo_in[l] = quo_q[l];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (advance) begin
            v_ff[k+1] <= v_q;
         end
         if (advance) begin
            den_ff[k+1] <= den_q;
            car_ff[k+1] <= car_q;
            for (int l = 0; l < 3; l++) begin
               num_ff[k+1][l] <= num_q[l];
               rem_ff[k+1][l] <= rem_in[l];
               quo_ff[k+1][l] <= quo_in[l];
               hi_ff[k+1][l] <= hi_q[l];
            end
         end
      end
   end

   assign out_valid = v_ff[QW];
   assign out_carry = car_ff[QW];
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         out_quo[l] = quo_ff[QW][l];
         out_sat[l] = hi_ff[QW][l];
      end
   end

endmodule

### rtl/axis_rotate_and_normalize_core.sv
// ----------------------------------------------------------------------------
// axis_rotate_and_normalize_core
// rotates a vector about x, y or z and scales it to unit length in q1.14
// ----------------------------------------------------------------------------
// usage:
//   req_ words carry axis, angle and three signed components; rsp_ words
//   carry the three q1.14 components and a zero_length flag
//   one rsp_ word per req_ word, in order
//   throughput: one word per cycle while rsp_ready is high, set by the fully pipelined datapath
//   pipeline stages for COMP_WIDTH 16: 4 rotate, 1 magnitude, 1 prescale,
//   1 square, 1 sum, 32 square root, 16 divide and 1 output; the root
//   width follows the 64 bit sum and the divide depth the 16 bit quotient
//   reset clears every valid bit; payload registers are not reset
//   when rsp_ready is low and an output word is waiting the whole pipeline holds; req_ready follows
//   rsp_ready or an empty output stage, so no word is lost or repeated
//   axis code 3 skips rotation and only normalizes
// ----------------------------------------------------------------------------
module axis_rotate_and_normalize_core #(
   parameter int COMP_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_axis,
   input  logic [15:0]                  req_angle,
   input  logic signed [COMP_WIDTH-1:0] req_in_x,
   input  logic signed [COMP_WIDTH-1:0] req_in_y,
   input  logic signed [COMP_WIDTH-1:0] req_in_z,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [15:0]           rsp_out_x,
   output logic signed [15:0]           rsp_out_y,
   output logic signed [15:0]           rsp_out_z,
   output logic                         rsp_zero_length
);
   import arn_pkg::*;

   localparam int RW = COMP_WIDTH + 18;
   localparam int MW = RW - 1;

   logic advance;
   logic rot_valid;
   logic signed [RW-1:0] rx, ry, rz;

   // pipeline holds as one when the output word is not taken
   assign advance = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   arn_rotate #(.COMP_WIDTH(COMP_WIDTH)) u_rotate (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(req_valid), .in_axis(req_axis), .in_angle(req_angle),
      .in_x(req_in_x), .in_y(req_in_y), .in_z(req_in_z),
      .out_valid(rot_valid), .out_rx(rx), .out_ry(ry), .out_rz(rz)
   );

   // magnitudes, signs and prescale so the largest is below 2^31
   logic [MW-1:0] ma, mb, mc, mmax;
   logic [MW-1:0] mag_ff [3];
   logic [2:0]    neg_ff, neg3_ff, neg4_ff;
   logic          v3_ff, v4_ff, v5_ff;
   logic [MAG_WIDTH-1:0] sm_ff [3], sm4_ff [3];
   logic [MAG_WIDTH-1:0] sm_in [3];
   logic [61:0]   sq_ff [3];
   logic [SUM_WIDTH-1:0] sum_ff;
   logic [MAG_WIDTH-1:0] sm5_ff [3];
   logic [2:0]    neg5_ff;

   always_comb begin
      ma = rx[RW-1] ? MW'(-rx) : MW'(rx);
      mb = ry[RW-1] ? MW'(-ry) : MW'(ry);
      mc = rz[RW-1] ? MW'(-rz) : MW'(rz);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= rot_valid;
      end
      if (advance) begin
         mag_ff[0] <= ma;
         mag_ff[1] <= mb;
         mag_ff[2] <= mc;
         neg_ff <= {rz[RW-1], ry[RW-1], rx[RW-1]};
      end
   end

   // shift count: enough to bring the largest magnitude below 2^31
   logic [7:0] shamt;
   always_comb begin
      mmax = mag_ff[0];
      if (mag_ff[1] > mmax) mmax = mag_ff[1];
      if (mag_ff[2] > mmax) mmax = mag_ff[2];
      shamt = '0;
      for (int b = MAG_WIDTH; b < MW; b++) begin
         if (mmax[b]) shamt = 8'(b - MAG_WIDTH + 1);
      end
      for (int l = 0; l < 3; l++) sm_in[l] = MAG_WIDTH'(mag_ff[l] >> shamt);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (advance) begin
         v4_ff <= v3_ff;
      end
      if (advance) begin
         sm_ff <= sm_in;
         neg3_ff <= neg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (advance) begin
         v5_ff <= v4_ff;
      end
      if (advance) begin
         for (int l = 0; l < 3; l++) sq_ff[l] <= 62'(sm_ff[l]) * 62'(sm_ff[l]);
         sm4_ff <= sm_ff;
         neg4_ff <= neg3_ff;
      end
   end

   logic v6_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (advance) begin
         v6_ff <= v5_ff;
      end
      if (advance) begin
         sum_ff <= SUM_WIDTH'(sq_ff[0]) + SUM_WIDTH'(sq_ff[1]) + SUM_WIDTH'(sq_ff[2]);
         sm5_ff <= sm4_ff;
         neg5_ff <= neg4_ff;
      end
   end

   // carry magnitudes and signs alongside the root
   localparam int CW = 3 * MAG_WIDTH + 3;
   logic [CW-1:0] car_in, car_out;
   logic          sq_valid;
   logic [ROOT_WIDTH-1:0] root;
   assign car_in = {neg5_ff, sm5_ff[2], sm5_ff[1], sm5_ff[0]};

   arn_sqrt #(.SW(SUM_WIDTH), .CW(CW)) u_sqrt (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(v6_ff), .in_sum(sum_ff), .in_carry(car_in),
      .out_valid(sq_valid), .out_root(root), .out_carry(car_out)
   );

   logic [NUM_WIDTH-1:0] num [3];
   logic [2:0]           sgn;
   logic                 zero;
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         num[l] = (NUM_WIDTH'(car_out[l*MAG_WIDTH +: MAG_WIDTH]) << 14)
                + NUM_WIDTH'(root >> 1);
      end
      sgn = car_out[CW-1 -: 3];
      zero = (root == '0);
   end

   logic                 dv;
   logic [QUO_WIDTH-1:0] quo [3];
   logic                 sat [3];
   logic [3:0]           dcar;

   // zero root guarded by dividing by one; flag forces zero outputs
   arn_divide #(.NW(NUM_WIDTH), .DW(ROOT_WIDTH), .QW(QUO_WIDTH), .CW(4)) u_divide (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(sq_valid), .in_num(num),
      .in_den(zero ? ROOT_WIDTH'(1) : root), .in_carry({zero, sgn}),
      .out_valid(dv), .out_quo(quo), .out_sat(sat), .out_carry(dcar)
   );

   logic                 ov_ff;
   logic signed [15:0]   o_ff [3];
   logic                 z_ff;
   logic [QUO_WIDTH-1:0] qc [3];

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         qc[l] = (sat[l] || quo[l] > QUO_WIDTH'(UNIT)) ? QUO_WIDTH'(UNIT) : quo[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (advance) begin
         ov_ff <= dv;
      end
      if (advance) begin
         z_ff <= dcar[3];
         for (int l = 0; l < 3; l++) begin
            if (dcar[3]) o_ff[l] <= '0;
            else if (dcar[l]) o_ff[l] <= -$signed(OUT_WIDTH'(qc[l]));
            else o_ff[l] <= $signed(OUT_WIDTH'(qc[l]));
         end
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_out_x = o_ff[0];
   assign rsp_out_y = o_ff[1];
   assign rsp_out_z = o_ff[2];
   assign rsp_zero_length = z_ff;

   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_length |-> rsp_out_x == 0 && rsp_out_y == 0 && rsp_out_z == 0)
      else $error("zero length word with nonzero components");
   a_range_x: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_x <= 16384 && rsp_out_x >= -16384)
      else $error("out_x out of range");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x))
      else $error("stalled word changed");

endmodule

### tb/axis_rotate_and_normalize_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_rotate_and_normalize_checker
// watches the req_ and rsp_ channels of the rotate and normalize core,
// computes the expected unit vector for each accepted word and compares
// every accepted rsp_ word field by field in order
// ----------------------------------------------------------------------------
module axis_rotate_and_normalize_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_axis,
   input  logic [15:0]        req_angle,
   input  logic signed [15:0] req_in_x,
   input  logic signed [15:0] req_in_y,
   input  logic signed [15:0] req_in_z,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [15:0] rsp_out_x,
   input  logic signed [15:0] rsp_out_y,
   input  logic signed [15:0] rsp_out_z,
   input  logic               rsp_zero_length,
   output int                 fail_count,
   output int                 pending_count,
   output int                 word_count,
   output int                 zero_count
);
   import arn_pkg::*;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic               zero;
   } unit_vec_type;

   unit_vec_type unit_queue[$];

   assign pending_count = unit_queue.size();

   function automatic longint poly_sine(input longint u);
      longint x2, t, r, p;
      x2 = (u * u) >>> 14;
      t = 21024 - ((2320 * x2) >>> 14);
      r = 51472 - ((t * x2) >>> 14);
      p = (r * u) >>> 14;
      if (p > 32768) p = 32768;
      return p;
   endfunction

   function automatic longint int_root(input longint unsigned s);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv >>= 2;
      while (bitv != 0) begin
         if (s >= res + bitv) begin
            s -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic unit_vec_type rotate_normalize(input logic [1:0] axis,
         input logic [15:0] angle, input logic signed [15:0] ix,
         input logic signed [15:0] iy, input logic signed [15:0] iz);
      longint s0, c0, sn, cs, vx, vy, vz, top;
      longint r[3];
      longint unsigned mag[3], sum, n, q;
      logic neg[3];
      logic signed [15:0] o[3];
      unit_vec_type res;
      vx = ix;
      vy = iy;
      vz = iz;
      s0 = poly_sine(angle[13:0]);
      c0 = poly_sine(16384 - angle[13:0]);
      case (angle[15:14])
         2'd0: begin sn = s0; cs = c0; end
         2'd1: begin sn = c0; cs = -s0; end
         2'd2: begin sn = -s0; cs = -c0; end
         default: begin sn = -c0; cs = s0; end
      endcase
      r[0] = vx * 32768;
      r[1] = vy * 32768;
      r[2] = vz * 32768;
      if (axis == AXIS_X) begin
         r[1] = cs * vy - sn * vz;
         r[2] = sn * vy + cs * vz;
      end else if (axis == AXIS_Y) begin
         r[0] = cs * vx + sn * vz;
         r[2] = cs * vz - sn * vx;
      end else if (axis == AXIS_Z) begin
         r[0] = cs * vx - sn * vy;
         r[1] = sn * vx + cs * vy;
      end
      top = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = r[i] < 0;
         mag[i] = neg[i] ? -r[i] : r[i];
         if (mag[i] > top) top = mag[i];
      end
      while (top >= (64'd1 << 31)) begin
         top >>= 1;
         for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      if (sum == 0) begin
         res = '{x: 0, y: 0, z: 0, zero: 1'b1};
         return res;
      end
      n = int_root(sum);
      for (int i = 0; i < 3; i++) begin
         q = (mag[i] * 16384 + (n >> 1)) / n;
         if (q > UNIT) q = UNIT;
         o[i] = neg[i] ? -16'(q) : 16'(q);
      end
      res = '{x: o[0], y: o[1], z: o[2], zero: 1'b0};
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %0t: %s got %0d want %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      word_count = 0;
      zero_count = 0;
   end

   always @(posedge clock) begin
      unit_vec_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            unit_queue.push_back(rotate_normalize(req_axis, req_angle,
               req_in_x, req_in_y, req_in_z));
         if (rsp_valid && rsp_ready) begin
            word_count++;
            if (rsp_zero_length) zero_count++;
            if (unit_queue.size() == 0) begin
               report_mismatch("rsp words with nothing expected", 1, 0);
            end else begin
               want = unit_queue.pop_front();
               if (rsp_out_x !== want.x) report_mismatch("out_x", rsp_out_x, want.x);
               if (rsp_out_y !== want.y) report_mismatch("out_y", rsp_out_y, want.y);
               if (rsp_out_z !== want.z) report_mismatch("out_z", rsp_out_z, want.z);
               if (rsp_zero_length !== want.zero)
                  report_mismatch("zero_length", rsp_zero_length, want.zero);
            end
         end
      end
   end
endmodule

### tb/axis_rotate_and_normalize_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_rotate_and_normalize_core_test
// drives directed and random vectors with random gaps and stalls into the
// core, including a long output hold-off, and reports the checker verdict
// ----------------------------------------------------------------------------
module axis_rotate_and_normalize_core_test;
   import arn_pkg::*;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_axis;
   logic [15:0]        req_angle;
   logic signed [15:0] req_in_x;
   logic signed [15:0] req_in_y;
   logic signed [15:0] req_in_z;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [15:0] rsp_out_x;
   logic signed [15:0] rsp_out_y;
   logic signed [15:0] rsp_out_z;
   logic               rsp_zero_length;
   int                 fail_count;
   int                 pending_count;
   int                 word_count;
   int                 zero_count;
   int                 sent_count;
   logic               quiet_phase;
   logic               hold_done;

   axis_rotate_and_normalize_core #(.COMP_WIDTH(16)) dut (.*);

   axis_rotate_and_normalize_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("Some tests failed");
      $finish;
   end

   // receiver: random stalls, one long hold-off, one quiet stretch
   initial begin
      rsp_ready = 0;
      hold_done = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (!hold_done && sent_count >= 40) begin
            rsp_ready <= 0;
            for (int i = 0; i < 300; i++) @(negedge clock);
            hold_done = 1;
         end else begin
            rsp_ready <= quiet_phase || ($urandom_range(99) >= 15);
         end
      end
   end

   task automatic send_word(input logic [1:0] axis, input logic [15:0] angle,
         input logic signed [15:0] vx, input logic signed [15:0] vy,
         input logic signed [15:0] vz);
      while (!quiet_phase && $urandom_range(99) < 15) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_axis <= axis;
      req_angle <= angle;
      req_in_x <= vx;
      req_in_y <= vy;
      req_in_z <= vz;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_comp();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($urandom_range(8)) - 16'd4;
         3: return 16'd0;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int waited;
      reset = 1;
      req_valid = 0;
      req_axis = AXIS_X;
      req_angle = 0;
      req_in_x = 0;
      req_in_y = 0;
      req_in_z = 0;
      sent_count = 0;
      quiet_phase = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;
      // directed corners
      send_word(AXIS_X, 16'h0000, 0, 0, 0);
      send_word(AXIS_Z, 16'h1234, 0, 0, 0);
      send_word(AXIS_X, 16'h0000, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_word(AXIS_Y, 16'hffff, -16'sh8000, -16'sh8000, -16'sh8000);
      send_word(AXIS_Z, 16'h4000, 16'sh7fff, 0, 0);
      send_word(AXIS_X, 16'h8000, 0, 16'sh7fff, -16'sh8000);
      send_word(AXIS_Y, 16'hc000, 1, 0, 0);
      send_word(AXIS_Z, 16'h2000, 0, 1, 0);
      send_word(2'd3, 16'h5555, 3, -4, 0);
      send_word(2'd3, 16'haaaa, 0, 0, 0);
      send_word(AXIS_Y, 16'h3fff, 0, 0, 1);
      send_word(AXIS_X, 16'h4001, -1, -1, -1);
      send_word(AXIS_Z, 16'hbfff, 16'sh5555, -16'sh2aab, 16'sh1234);
      send_word(AXIS_Y, 16'h7fff, 16'sh7fff, -16'sh8000, 16'sh0001);
      // random, with a stretch without idling in the middle
      for (int i = 0; i < 800; i++) begin
         quiet_phase = (i >= 300 && i < 450);
         send_word(2'($urandom_range(3)), 16'($urandom), pick_comp(), pick_comp(),
            pick_comp());
      end
      quiet_phase = 0;
      req_valid <= 0;
      waited = 0;
      while (pending_count != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (80) @(posedge clock);
      $display("sent %0d vectors on all axis codes; %0d results checked, %0d zero length",
         sent_count, word_count, zero_count);
      if (fail_count == 0 && pending_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule

### files.f
rtl/arn_pkg.sv
rtl/arn_rotate.sv
rtl/arn_sqrt.sv
rtl/arn_divide.sv
rtl/axis_rotate_and_normalize_core.sv
tb/axis_rotate_and_normalize_checker.sv
tb/axis_rotate_and_normalize_core_test.sv
